// File: hdl/hamming_tolerant_code_lookup_defines.svh
// Assertion helpers shared by the checker.
`ifndef HAMMING_TOLERANT_CODE_LOOKUP_DEFINES_SVH
`define HAMMING_TOLERANT_CODE_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HTCL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("htcl check failed");

// Next-cycle implication.
`define HTCL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("htcl check failed");

`endif

// File: hdl/htcl_pkg.sv
`default_nettype none
package htcl_pkg;

	localparam int TABLE_DEPTH_DEF = 65536;
	localparam int CODE_WIDTH_DEF  = 52;
	localparam int CFG_W           = 17;

	localparam logic [15:0] MISS_ID   = 16'hFFFF;
	localparam logic [7:0]  MISS_DIST = 8'hFF;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic [1:0] REG_CODE_BITS     = 2'd0;
	localparam logic [1:0] REG_MAX_HAMMING   = 2'd1;
	localparam logic [1:0] REG_TABLE_ENTRIES = 2'd2;

	localparam logic [5:0]       CODE_BITS_RST     = 6'd36;
	localparam logic [1:0]       MAX_HAMMING_RST   = 2'd2;
	localparam logic [CFG_W-1:0] TABLE_ENTRIES_RST = 17'd65536;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic hash_start;
		logic probe_init;
		logic rd;
		logic probe_next;
		logic wr;
		logic var_next;
		logic rot;
		logic fin_plain;
		logic fin_full;
		logic fin_hit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic hit_valid;
		logic hit_match;
		logic probe_last;
		logic var_done;
		logic rot_last;
		logic is_add;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/htcl_divider.sv
`default_nettype none
// Restoring remainder, one dividend bit per cycle.
module htcl_divider import htcl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int CODE_WIDTH  = CODE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [CODE_WIDTH-1:0]          dividend,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] modulus,
	output logic                                done,
	output logic [$clog2(TABLE_DEPTH)-1:0]      rem
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int MW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = $clog2(CODE_WIDTH + 1);

	logic [CODE_WIDTH-1:0] dvd_q;
	logic [MW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [MW:0]           trial;
	logic [MW:0]           trial_sub;

	always_comb begin
		trial = {rem_q, dvd_q[CODE_WIDTH-1]};
		trial_sub = (trial >= {1'b0, modulus}) ? trial - {1'b0, modulus} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(CODE_WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= trial_sub[MW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[AW-1:0];
endmodule
`default_nettype wire

// File: hdl/htcl_datapath.sv
`default_nettype none
module htcl_datapath import htcl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int CODE_WIDTH  = CODE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic [1:0]            in_action,
	input  wire logic [CODE_WIDTH-1:0] in_code,
	input  wire logic [15:0]           in_tag_id,
	output logic                       done,
	output logic                       status,
	output logic                       found,
	output logic [15:0]                match_id,
	output logic [7:0]                 match_distance,
	output logic [1:0]                 match_rotation,
	output logic [CODE_WIDTH-1:0]      match_code
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int MW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(CODE_WIDTH + 1);
	localparam int IW = $clog2(CODE_WIDTH);
	localparam int XW = (MW > CFG_W) ? MW : CFG_W;
	localparam int YW = (NW > 6) ? NW : 6;

	logic [5:0]       code_bits_q;
	logic [1:0]       max_ham_q;
	logic [CFG_W-1:0] entries_q;
	logic [MW-1:0]    modulus;
	logic [NW-1:0]    n_eff;

	logic [1:0]            act_q;
	logic [CODE_WIDTH-1:0] base_q;
	logic [CODE_WIDTH-1:0] key_q;
	logic [15:0]           id_q;
	logic [1:0]            lvl_q;
	logic [IW-1:0]         j_q, k_q, m_q;
	logic [1:0]            rot_q;
	logic [AW-1:0]         bucket_q;
	logic [MW-1:0]         probes_q;
	logic [AW-1:0]         clr_addr_q;

	logic [CODE_WIDTH:0]   code_mem [TABLE_DEPTH];
	logic [17:0]           info_mem [TABLE_DEPTH];
	logic [CODE_WIDTH:0]   rd_code_q;
	logic [17:0]           rd_info_q;

	logic                  div_done;
	logic [AW-1:0]         div_rem;
	logic [MW-1:0]         bucket_inc;
	logic [AW-1:0]         bucket_nxt;

	logic [1:0]            nl;
	logic [IW-1:0]         nj, nk, nm;
	logic                  vdone;
	logic [CODE_WIDTH-1:0] flip;

	logic                  ql;
	logic [NW-1:0]         qp;
	logic [NW+1:0]         qp3;
	logic [NW-1:0]         qs1;
	logic [NW+1:0]         qs2;
	logic [CODE_WIDTH-1:0] qmask;
	logic [CODE_WIDTH-1:0] turned;

	logic                  done_q, status_q, found_q;
	logic [15:0]           id_res_q;
	logic [7:0]            dist_res_q;
	logic [1:0]            rot_res_q;
	logic [CODE_WIDTH-1:0] code_res_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q <= CODE_BITS_RST;
			max_ham_q   <= MAX_HAMMING_RST;
			entries_q   <= TABLE_ENTRIES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CODE_BITS:     code_bits_q <= cfg_data[5:0];
				REG_MAX_HAMMING:   max_ham_q   <= cfg_data[1:0];
				REG_TABLE_ENTRIES: entries_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (XW'(entries_q) == '0) modulus = MW'(1);
		else if (XW'(entries_q) > XW'(TABLE_DEPTH)) modulus = MW'(TABLE_DEPTH);
		else modulus = MW'(entries_q);
		if (YW'(code_bits_q) < YW'(4)) n_eff = NW'(4);
		else if (YW'(code_bits_q) > YW'(CODE_WIDTH)) n_eff = NW'(CODE_WIDTH);
		else n_eff = NW'(code_bits_q);
	end

	// next flip pattern: single bits, then pairs, then triples
	always_comb begin
		nl = lvl_q;
		nj = j_q;
		nk = k_q;
		nm = m_q;
		vdone = 1'b0;
		case (lvl_q)
			2'd0: begin
				if (max_ham_q >= 2'd1) begin
					nl = 2'd1;
					nj = '0;
				end else vdone = 1'b1;
			end
			2'd1: begin
				if (NW'(j_q) + NW'(1) < n_eff) nj = j_q + IW'(1);
				else if (max_ham_q >= 2'd2) begin
					nl = 2'd2;
					nj = IW'(1);
					nk = '0;
				end else vdone = 1'b1;
			end
			2'd2: begin
				if (k_q + IW'(1) < j_q) nk = k_q + IW'(1);
				else if (NW'(j_q) + NW'(1) < n_eff) begin
					nj = j_q + IW'(1);
					nk = '0;
				end else if (max_ham_q == 2'd3) begin
					nl = 2'd3;
					nj = IW'(2);
					nk = IW'(1);
					nm = '0;
				end else vdone = 1'b1;
			end
			default: begin
				if (m_q + IW'(1) < k_q) nm = m_q + IW'(1);
				else if (k_q + IW'(1) < j_q) begin
					nk = k_q + IW'(1);
					nm = '0;
				end else if (NW'(j_q) + NW'(1) < n_eff) begin
					nj = j_q + IW'(1);
					nk = IW'(1);
					nm = '0;
				end else vdone = 1'b1;
			end
		endcase
		flip = ((nl >= 2'd1) ? (CODE_WIDTH'(1) << nj) : '0)
			^ ((nl >= 2'd2) ? (CODE_WIDTH'(1) << nk) : '0)
			^ ((nl == 2'd3) ? (CODE_WIDTH'(1) << nm) : '0);
	end

	// quarter turn; odd sizes of the form 4q+1 keep the centre bit in place
	always_comb begin
		ql     = (n_eff[1:0] == 2'b01);
		qp     = n_eff - NW'(ql);
		qp3    = (NW+2)'(qp) * (NW+2)'(3);
		qs1    = NW'(qp >> 2) + NW'(ql);
		qs2    = (qp3 >> 2) + (NW+2)'(ql);
		qmask  = {CODE_WIDTH{1'b1}} >> (NW'(CODE_WIDTH) - n_eff);
		turned = (((key_q >> ql) << qs1) | ((key_q >> qs2) << ql)
			| (key_q & CODE_WIDTH'(ql))) & qmask;
	end

	htcl_divider #(.TABLE_DEPTH(TABLE_DEPTH), .CODE_WIDTH(CODE_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.hash_start),
		.dividend (key_q),
		.modulus  (modulus),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		bucket_inc = MW'(bucket_q) + MW'(1);
		bucket_nxt = (bucket_inc >= modulus) ? '0 : AW'(bucket_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.fin_plain | cmd.fin_full | cmd.fin_hit;
			if (cmd.load) clr_addr_q <= '0;
			else if (cmd.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= in_action;
			base_q <= in_code;
			key_q  <= in_code;
			id_q   <= in_tag_id;
			lvl_q  <= 2'd0;
			rot_q  <= 2'd0;
		end else if (cmd.var_next) begin
			lvl_q <= nl;
			j_q   <= nj;
			k_q   <= nk;
			m_q   <= nm;
			key_q <= base_q ^ flip;
		end else if (cmd.rot) begin
			key_q <= turned;
			rot_q <= rot_q + 2'd1;
		end
		if (cmd.probe_init) begin
			bucket_q <= div_rem;
			probes_q <= '0;
		end else if (cmd.probe_next) begin
			bucket_q <= bucket_nxt;
			probes_q <= probes_q + MW'(1);
		end
	end

	// bucket store: valid bit on top of the code word
	always_ff @(posedge clk) begin
		if (cmd.clr_step) code_mem[clr_addr_q] <= '0;
		else if (cmd.wr) code_mem[bucket_q] <= {1'b1, key_q};
		if (cmd.wr) info_mem[bucket_q] <= {id_q, lvl_q};
		if (cmd.rd) begin
			rd_code_q <= code_mem[bucket_q];
			rd_info_q <= info_mem[bucket_q];
		end
	end

	always_comb begin
		sts.clr_last   = (clr_addr_q == AW'(TABLE_DEPTH - 1));
		sts.hash_done  = div_done;
		sts.hit_valid  = rd_code_q[CODE_WIDTH];
		sts.hit_match  = (rd_code_q[CODE_WIDTH-1:0] == key_q);
		sts.probe_last = (probes_q == modulus - MW'(1));
		sts.var_done   = vdone;
		sts.rot_last   = (rot_q == 2'd3);
		sts.is_add     = (act_q == ACT_ADD);
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_hit) begin
			status_q   <= 1'b0;
			found_q    <= 1'b1;
			id_res_q   <= rd_info_q[17:2];
			dist_res_q <= {6'd0, rd_info_q[1:0]};
			rot_res_q  <= rot_q;
			code_res_q <= rd_code_q[CODE_WIDTH-1:0];
		end else if (cmd.fin_plain || cmd.fin_full) begin
			status_q   <= cmd.fin_full;
			found_q    <= 1'b0;
			id_res_q   <= MISS_ID;
			dist_res_q <= MISS_DIST;
			rot_res_q  <= 2'd0;
			code_res_q <= '0;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found          = found_q;
	assign match_id       = id_res_q;
	assign match_distance = dist_res_q;
	assign match_rotation = rot_res_q;
	assign match_code     = code_res_q;
endmodule
`default_nettype wire

// File: hdl/htcl_ctrl.sv
`default_nettype none
module htcl_ctrl import htcl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] action,
	input  wire sts_t       sts,
	output cmd_t            cmd,
	output logic            busy
);
	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_HSTART, S_HASH, S_RD, S_EV
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pend_d  = pend_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.fin_plain = pend_q;
					pend_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (action == ACT_CLEAR) begin
						pend_d  = 1'b1;
						state_d = S_CLR;
					end else if (action == ACT_ADD || action == ACT_LOOKUP) begin
						state_d = S_HSTART;
					end else begin
						cmd.fin_plain = 1'b1;
					end
				end
			end
			S_HSTART: begin
				cmd.hash_start = 1'b1;
				state_d = S_HASH;
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.probe_init = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				if (sts.is_add) begin
					if (!sts.hit_valid) begin
						cmd.wr = 1'b1;
						if (sts.var_done) begin
							cmd.fin_plain = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.var_next = 1'b1;
							state_d = S_HSTART;
						end
					end else if (sts.probe_last) begin
						cmd.fin_full = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.probe_next = 1'b1;
						state_d = S_RD;
					end
				end else begin
					if (sts.hit_valid && sts.hit_match) begin
						cmd.fin_hit = 1'b1;
						state_d = S_IDLE;
					end else if (sts.hit_valid && !sts.probe_last) begin
						cmd.probe_next = 1'b1;
						state_d = S_RD;
					end else if (sts.rot_last) begin
						cmd.fin_plain = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.rot = 1'b1;
						state_d = S_HSTART;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// reset starts with a sweep that empties the store, no result reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

// File: hdl/hamming_tolerant_code_lookup.sv
`default_nettype none
// Error-tolerant codeword lookup over an open-addressed hash store with linear
// probing, bucket = code mod table_entries. Give an item with start while busy
// is low; its result appears for exactly one cycle with done high and must be
// taken then, as there is no way to stall it. Every item gives one result. After
// reset, and for each clear item, a sweep writes every one of the TABLE_DEPTH
// buckets, one per cycle; busy stays high meanwhile. Each hash runs in the
// bit-serial remainder unit, and each probe reads the single-port store and then
// evaluates the entry; this is done for every orientation a lookup tries and
// for every variant an add inserts (1 + n + n(n-1)/2 and so on up to max_hamming),
// and the result follows in the cycle after the last probe is evaluated. An
// unknown action gives its result in the cycle after it is taken. A full store
// is found by probing all table_entries buckets and reported as status 1.
// Configuration writes are taken only while busy is low.
module hamming_tolerant_code_lookup import htcl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int CODE_WIDTH  = CODE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            action,
	input  wire logic [CODE_WIDTH-1:0] code,
	input  wire logic [15:0]           tag_id,
	output logic                       done,
	output logic                       status,
	output logic                       found,
	output logic [15:0]                match_id,
	output logic [7:0]                 match_distance,
	output logic [1:0]                 match_rotation,
	output logic [CODE_WIDTH-1:0]      match_code,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic ctrl_busy;

	htcl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	htcl_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .CODE_WIDTH(CODE_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_valid & ~ctrl_busy),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_action      (action),
		.in_code        (code),
		.in_tag_id      (tag_id),
		.done           (done),
		.status         (status),
		.found          (found),
		.match_id       (match_id),
		.match_distance (match_distance),
		.match_rotation (match_rotation),
		.match_code     (match_code)
	);

	assign busy      = ctrl_busy;
	assign cfg_ready = ~ctrl_busy;
endmodule
`default_nettype wire

// File: hdl/htcl_checker.sv
`default_nettype none
`include "hamming_tolerant_code_lookup_defines.svh"
module htcl_checker import htcl_pkg::*; #(
	parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic [1:0]            action,
	input wire logic                  done,
	input wire logic                  status,
	input wire logic                  found,
	input wire logic [15:0]           match_id,
	input wire logic [7:0]            match_distance,
	input wire logic [1:0]            match_rotation,
	input wire logic [CODE_WIDTH-1:0] match_code,
	input wire logic                  cfg_ready
);
	// a hit never comes with the full flag and carries a distance of at most three
	`HTCL_ASSERT_IMP(a_hit_fields, done && found, !status && match_distance <= 8'd3)
	`HTCL_ASSERT_IMP(a_miss_fields, done && !found, match_id == MISS_ID && match_distance == MISS_DIST && match_rotation == 2'd0 && match_code == '0)
	`HTCL_ASSERT_IMP(a_cfg_idle, cfg_ready, !busy)
	`HTCL_ASSERT_NXT(a_work_busy, start && !busy && (action == ACT_ADD || action == ACT_LOOKUP), busy)
endmodule

bind hamming_tolerant_code_lookup htcl_checker #(.CODE_WIDTH(CODE_WIDTH)) u_chk (.*);
`default_nettype wire
